// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level of the LFU cache.
// Define SYNTH to compile them away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("property violated");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

// ===== src/lfu_pkg.sv =====
// Shared types and constants of the LFU cache.
// No dependencies; lfu_store, lfu_rank, lfu_scan and lfu_cache import it.
`default_nettype none

package lfu_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CAPREG_W = 5;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam logic [CAPREG_W-1:0] CAP_RESET = 5'd16;

	// read_value on a get miss and on every put
	localparam logic [VAL_W-1:0] READ_MISS = '1;
	localparam logic [VAL_W-1:0] READ_PUT  = '0;

	// Rank table update issued at most once per transaction
	typedef struct packed {
		logic touch;   // make target most recent, age newer entries
		logic insert;  // age all live entries, place target at rank 0
		logic evict;   // with insert: drop victim and close its rank gap
	} lfu_rank_op_t;

endpackage

`default_nettype wire

// ===== src/lfu_req_if.sv =====
// Request channel of the LFU cache: valid/ready plus action, key, value.
// Depends on nothing.
`default_nettype none

interface lfu_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] key;
	logic signed [31:0] value;

	modport source (output valid, output action, output key, output value, input ready);
	modport sink   (input valid, input action, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== src/lfu_rsp_if.sv =====
// Response channel of the LFU cache: valid/ready plus found, read_value.
// Depends on nothing.
`default_nettype none

interface lfu_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] read_value;

	modport source (output valid, output found, output read_value, input ready);
	modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

// ===== src/lfu_store.sv =====
// Key, value and use-count memories of the LFU cache.
// One write port, registered reads; uses lfu_pkg.
`default_nettype none

module lfu_store #(
	parameter int CAPACITY   = 16,
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 4
) (
	input  wire logic                       clk,
	input  wire logic [IDX_W-1:0]           rd_idx,
	output logic [lfu_pkg::KEY_W-1:0]       key_rd_s1,
	output logic [COUNT_BITS-1:0]           cnt_rd_s1,
	input  wire logic                       val_re,
	input  wire logic [IDX_W-1:0]           val_ridx,
	output logic [lfu_pkg::VAL_W-1:0]       val_rd_s1,
	input  wire logic [IDX_W-1:0]           wr_idx,
	input  wire logic                       key_we,
	input  wire logic                       val_we,
	input  wire logic                       cnt_we,
	input  wire logic [lfu_pkg::KEY_W-1:0]  wr_key,
	input  wire logic [lfu_pkg::VAL_W-1:0]  wr_val,
	input  wire logic [COUNT_BITS-1:0]      wr_cnt
);
	import lfu_pkg::*;

	logic [KEY_W-1:0]      key_mem [CAPACITY];
	logic [VAL_W-1:0]      val_mem [CAPACITY];
	logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_idx] <= wr_key;
		end
		key_rd_s1 <= key_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[wr_idx] <= wr_cnt;
		end
		cnt_rd_s1 <= cnt_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[wr_idx] <= wr_val;
		end
		if (val_re) begin
			val_rd_s1 <= val_mem[val_ridx];
		end
	end

endmodule

`default_nettype wire

// ===== src/lfu_rank.sv =====
// Valid bits and recency ranks of the LFU cache, updated per entry in parallel.
// Rank 0 is the most recently touched entry; uses lfu_pkg.
`default_nettype none

module lfu_rank #(
	parameter int CAPACITY = 16,
	parameter int IDX_W    = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IDX_W-1:0]      rd_idx,
	output logic                       rd_vld_s1,
	output logic [IDX_W-1:0]           rd_rank_s1,
	output logic [CAPACITY-1:0]        vld,
	input  wire lfu_pkg::lfu_rank_op_t op,
	input  wire logic [IDX_W-1:0]      tgt_idx,
	input  wire logic [IDX_W-1:0]      vic_idx,
	input  wire logic [IDX_W-1:0]      ref_rank
);
	import lfu_pkg::*;

	logic [CAPACITY-1:0] vld_q;
	logic [CAPACITY-1:0] vld_d;
	logic [IDX_W-1:0]    rank_q [CAPACITY];
	logic [IDX_W-1:0]    rank_d [CAPACITY];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			vld_d[i]  = vld_q[i];
			rank_d[i] = rank_q[i];
			if (op.touch) begin
				if (IDX_W'(i) == tgt_idx) begin
					rank_d[i] = '0;
				end else if (vld_q[i] && (rank_q[i] < ref_rank)) begin
					rank_d[i] = rank_q[i] + 1'b1;
				end
			end
			if (op.insert) begin
				if (op.evict && (IDX_W'(i) == vic_idx)) begin
					vld_d[i] = 1'b0;
				end else if (vld_q[i]) begin
					// entries behind the victim move up one, then all age by one
					if (!(op.evict && (rank_q[i] > ref_rank))) begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
				if (IDX_W'(i) == tgt_idx) begin
					vld_d[i]  = 1'b1;
					rank_d[i] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		rank_q     <= rank_d;
		rd_vld_s1  <= vld_q[rd_idx];
		rd_rank_s1 <= rank_q[rd_idx];
	end

	assign vld = vld_q;

endmodule

`default_nettype wire

// ===== src/lfu_scan.sv =====
// Shared compare unit of the LFU cache: one entry per cycle for key match,
// occupancy, first free slot and LFU/LRU victim. Uses lfu_pkg.
`default_nettype none

module lfu_scan #(
	parameter int CAPACITY   = 16,
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 4,
	parameter int OCC_W      = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clear,
	input  wire logic                      sample,
	input  wire logic [IDX_W-1:0]          idx,
	input  wire logic                      ent_vld,
	input  wire logic [lfu_pkg::KEY_W-1:0] ent_key,
	input  wire logic [COUNT_BITS-1:0]     ent_cnt,
	input  wire logic [IDX_W-1:0]          ent_rank,
	input  wire logic [lfu_pkg::KEY_W-1:0] key_ref,
	output logic                           hit_q,
	output logic [IDX_W-1:0]               hit_idx_q,
	output logic [COUNT_BITS-1:0]          hit_cnt_q,
	output logic [IDX_W-1:0]               hit_rank_q,
	output logic [OCC_W-1:0]               occ_q,
	output logic                           free_found_q,
	output logic [IDX_W-1:0]               free_idx_q,
	output logic [IDX_W-1:0]               vic_idx_q,
	output logic [IDX_W-1:0]               vic_rank_q
);
	import lfu_pkg::*;

	logic                  vic_found_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic                  is_match;
	logic                  is_victim;

	assign is_match  = ent_vld && (ent_key == key_ref) && !hit_q;
	assign is_victim = ent_vld && (!vic_found_q || (ent_cnt < vic_cnt_q) ||
		((ent_cnt == vic_cnt_q) && (ent_rank > vic_rank_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			occ_q        <= '0;
		end else if (clear) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			occ_q        <= '0;
		end else if (sample) begin
			occ_q <= occ_q + OCC_W'(ent_vld);
			if (is_match) begin
				hit_q <= 1'b1;
			end
			if (!ent_vld) begin
				free_found_q <= 1'b1;
			end
			if (is_victim) begin
				vic_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample) begin
			if (is_match) begin
				hit_idx_q  <= idx;
				hit_cnt_q  <= ent_cnt;
				hit_rank_q <= ent_rank;
			end
			if (!ent_vld && !free_found_q) begin
				free_idx_q <= idx;
			end
			if (is_victim) begin
				vic_idx_q  <= idx;
				vic_cnt_q  <= ent_cnt;
				vic_rank_q <= ent_rank;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/lfu_cache.sv =====
// Top level of the LFU cache: sequencer, config register, response register.
// Uses lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_store, lfu_rank, lfu_scan, assert_macros.svh.
//
// Usage
//  - req (sink) carries one get or put transaction: action (0 get, 1 put), key, value.
//  - rsp (source) returns one transaction per request: found and read_value
//    (stored value on a get hit, -1 on a get miss, 0 for every put).
//  - cfg_we/cfg_wdata write capacity_in_use; write it only while the block is idle.
// Timing
//  - After a request is taken, every entry is visited once through the shared
//    compare unit (one memory read per cycle); the drain state then empties the
//    read pipe, the decide state updates the tables and the done state loads rsp.
//  - A new request is taken only after the last one leaves the final stage; req.ready
//    is high only while the sequencer is idle.
// Reset and stall
//  - arst_n clears all valid bits (empty cache), sets capacity_in_use to 16 and
//    drops any pending response. Memories are not cleared; only valid entries count in the scan.
//  - A response waiting on rsp.ready holds; the next request is still accepted and
//    runs its scan, then waits in the final stage until the response register frees.
`default_nettype none
`include "assert_macros.svh"

module lfu_cache #(
	parameter int CAPACITY   = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lfu_req_if.sink                            req,
	lfu_rsp_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [lfu_pkg::CAPREG_W-1:0]  cfg_wdata
);
	import lfu_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OCC_W > CAPREG_W) ? OCC_W : CAPREG_W;

	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(CAPACITY - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic                samp_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [CAPREG_W-1:0] cap_q;
	logic                act_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic                rsp_valid_q;
	logic                rsp_found_q;
	logic [VAL_W-1:0]    rsp_read_q;

	// scan results
	logic                  scn_hit;
	logic [IDX_W-1:0]      scn_hit_idx;
	logic [COUNT_BITS-1:0] scn_hit_cnt;
	logic [IDX_W-1:0]      scn_hit_rank;
	logic [OCC_W-1:0]      scn_occ;
	logic                  scn_free_found;
	logic [IDX_W-1:0]      scn_free_idx;
	logic [IDX_W-1:0]      scn_vic_idx;
	logic [IDX_W-1:0]      scn_vic_rank;

	// table read data, aligned with samp_s1
	logic                  ent_vld_s1;
	logic [IDX_W-1:0]      ent_rank_s1;
	logic [KEY_W-1:0]      ent_key_s1;
	logic [COUNT_BITS-1:0] ent_cnt_s1;
	logic [VAL_W-1:0]      val_rd_s1;
	logic [CAPACITY-1:0]   ent_vld;

	logic                  req_take;
	logic                  rsp_load;
	logic                  in_decide;
	logic                  is_put;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      cap_eff;
	logic                  cap_zero;
	logic                  evict;
	logic                  free_first;
	logic [IDX_W-1:0]      slot;
	logic                  do_bump;
	logic                  do_insert;
	logic [IDX_W-1:0]      wr_idx;
	logic [COUNT_BITS-1:0] cnt_sat;
	lfu_rank_op_t          rank_op;

	assign req_take = req.valid && req.ready;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.read_value = rsp_read_q;

	// Capacities above the array size act as the array size
	assign cap_ext  = CMP_W'(cap_q);
	assign cap_eff  = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
	assign cap_zero = (cap_eff == '0);

	assign in_decide = (state_q == ST_DECIDE);
	assign is_put    = (act_q == ACT_PUT);
	assign evict     = (CMP_W'(scn_occ) >= cap_eff);

	// Reuse the lowest free index; after an eviction the victim's slot also counts
	assign free_first = scn_free_found && (!evict || (scn_free_idx < scn_vic_idx));
	assign slot       = free_first ? scn_free_idx : scn_vic_idx;

	assign do_bump   = in_decide && scn_hit && (!is_put || !cap_zero);
	assign do_insert = in_decide && is_put && !cap_zero && !scn_hit &&
		(evict || scn_free_found);

	assign wr_idx  = do_insert ? slot : scn_hit_idx;
	assign cnt_sat = (scn_hit_cnt == CNT_MAX) ? scn_hit_cnt : scn_hit_cnt + 1'b1;

	assign rank_op.touch  = do_bump;
	assign rank_op.insert = do_insert;
	assign rank_op.evict  = do_insert && evict;

	// Sequencer: idle -> scan all entries -> drain read pipe -> update -> respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			samp_s1 <= 1'b0;
		end else begin
			samp_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the response register is free
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (req_take) begin
			act_q <= req.action;
			key_q <= req.key;
			val_q <= req.value;
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Response register: load from the final stage, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_found_q <= scn_hit;
			if (is_put) begin
				rsp_read_q <= READ_PUT;
			end else if (scn_hit) begin
				rsp_read_q <= val_rd_s1;
			end else begin
				rsp_read_q <= READ_MISS;
			end
		end
	end

	lfu_store #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk       (clk),
		.rd_idx    (idx_q),
		.key_rd_s1 (ent_key_s1),
		.cnt_rd_s1 (ent_cnt_s1),
		.val_re    (in_decide),
		.val_ridx  (scn_hit_idx),
		.val_rd_s1 (val_rd_s1),
		.wr_idx    (wr_idx),
		.key_we    (do_insert),
		.val_we    (do_insert || (do_bump && is_put)),
		.cnt_we    (do_insert || do_bump),
		.wr_key    (key_q),
		.wr_val    (val_q),
		.wr_cnt    (do_insert ? CNT_ONE : cnt_sat)
	);

	lfu_rank #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W)
	) u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_idx     (idx_q),
		.rd_vld_s1  (ent_vld_s1),
		.rd_rank_s1 (ent_rank_s1),
		.vld        (ent_vld),
		.op         (rank_op),
		.tgt_idx    (wr_idx),
		.vic_idx    (scn_vic_idx),
		.ref_rank   (do_insert ? scn_vic_rank : scn_hit_rank)
	);

	lfu_scan #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W),
		.OCC_W      (OCC_W)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (req_take),
		.sample       (samp_s1),
		.idx          (idx_s1),
		.ent_vld      (ent_vld_s1),
		.ent_key      (ent_key_s1),
		.ent_cnt      (ent_cnt_s1),
		.ent_rank     (ent_rank_s1),
		.key_ref      (key_q),
		.hit_q        (scn_hit),
		.hit_idx_q    (scn_hit_idx),
		.hit_cnt_q    (scn_hit_cnt),
		.hit_rank_q   (scn_hit_rank),
		.occ_q        (scn_occ),
		.free_found_q (scn_free_found),
		.free_idx_q   (scn_free_idx),
		.vic_idx_q    (scn_vic_idx),
		.vic_rank_q   (scn_vic_rank)
	);

	// A match found by the scan must point at a live entry
	`ASSERT_PROP(a_hit_is_live, clk, arst_n, (in_decide && scn_hit) |-> ent_vld[scn_hit_idx])
	// The entry tables stay frozen while they are being scanned
	`ASSERT_PROP(a_scan_frozen, clk, arst_n, (state_q == ST_SCAN) |=> $stable(ent_vld))
	// A new response only comes out of the final stage
	`ASSERT_PROP(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
	// An insert never lands on a live entry other than the one being evicted
	`ASSERT_NEVER(a_insert_clobber, clk, arst_n, do_insert && ent_vld[slot] && !(evict && (slot == scn_vic_idx)))

endmodule

`default_nettype wire

// ===== tb/sv/lfu_cache_tb.sv =====
// Self-checking testbench for the LFU cache (lfu_cache).
// Depends on lfu_pkg, lfu_req_if and lfu_rsp_if from the RTL; holds its own
// LFU/LRU predictor in a scoreboard class and drives the block with plain tasks.
`timescale 1ns / 100ps

module lfu_cache_tb;
	import lfu_pkg::*;

	localparam int N_ENTRIES   = 16;
	localparam int CNT_W       = 16;
	localparam int LATENCY     = N_ENTRIES + 3;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value;
	} lfu_result_t;

	// Scoreboard: mirrors the cache contents and queues expected responses.
	class lfu_scoreboard;
		logic [CAPREG_W-1:0] cap_reg;
		bit                  ent_valid [N_ENTRIES];
		logic [KEY_W-1:0]    ent_key   [N_ENTRIES];
		logic [VAL_W-1:0]    ent_val   [N_ENTRIES];
		logic [CNT_W-1:0]    ent_cnt   [N_ENTRIES];
		logic [3:0]          ent_rank  [N_ENTRIES];
		lfu_result_t         expected_q[$];
		int                  errors;
		int                  n_checked;
		int                  n_hits;
		int                  n_evictions;

		function new();
			cap_reg = CAP_RESET;
			foreach (ent_valid[i]) ent_valid[i] = 1'b0;
		endfunction

		function void write_capacity(logic [CAPREG_W-1:0] c);
			cap_reg = c;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Raise the use count (saturating) and make entry e the most recent.
		function void promote(int e);
			logic [3:0] r;
			r = ent_rank[e];
			if (ent_cnt[e] != '1) ent_cnt[e]++;
			for (int i = 0; i < N_ENTRIES; i++)
				if (ent_valid[i] && i != e && ent_rank[i] < r) ent_rank[i]++;
			ent_rank[e] = '0;
		endfunction

		function void note_request(logic act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
			int          hit;
			int          victim;
			int          slot;
			int          occupied;
			int          lim;
			lfu_result_t res;
			hit      = -1;
			victim   = -1;
			slot     = -1;
			occupied = 0;
			lim      = (cap_reg > N_ENTRIES) ? N_ENTRIES : int'(cap_reg);
			for (int i = 0; i < N_ENTRIES; i++)
				if (hit < 0 && ent_valid[i] && ent_key[i] == k) hit = i;
			res.found = (hit >= 0);
			res.value = READ_PUT;
			if (act == ACT_GET) begin
				if (hit >= 0) begin
					res.value = ent_val[hit];
					promote(hit);
				end else begin
					res.value = READ_MISS;
				end
			end else if (lim != 0) begin
				if (hit >= 0) begin
					ent_val[hit] = v;
					promote(hit);
				end else begin
					foreach (ent_valid[i]) if (ent_valid[i]) occupied++;
					if (occupied >= lim) begin
						// lowest count loses; on a tie the least recently touched
						for (int i = 0; i < N_ENTRIES; i++) begin
							if (!ent_valid[i]) continue;
							if (victim < 0 || ent_cnt[i] < ent_cnt[victim] ||
							    (ent_cnt[i] == ent_cnt[victim] &&
							     ent_rank[i] > ent_rank[victim]))
								victim = i;
						end
						if (victim >= 0) begin
							for (int i = 0; i < N_ENTRIES; i++)
								if (ent_valid[i] && ent_rank[i] > ent_rank[victim])
									ent_rank[i]--;
							ent_valid[victim] = 1'b0;
							n_evictions++;
						end
					end
					for (int i = 0; i < N_ENTRIES; i++)
						if (slot < 0 && !ent_valid[i]) slot = i;
					if (slot >= 0) begin
						for (int i = 0; i < N_ENTRIES; i++)
							if (ent_valid[i]) ent_rank[i]++;
						ent_valid[slot] = 1'b1;
						ent_key[slot]   = k;
						ent_val[slot]   = v;
						ent_cnt[slot]   = CNT_W'(1);
						ent_rank[slot]  = '0;
					end
				end
			end
			expected_q.push_back(res);
		endfunction

		function void check_response(logic f, logic [VAL_W-1:0] rv);
			lfu_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected response: found=%0b read_value=%h", f, rv);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			n_checked++;
			if (exp_r.found) n_hits++;
			if (f !== exp_r.found) begin
				$error("found: expected %0b, actual %0b", exp_r.found, f);
				errors++;
			end
			if (rv !== exp_r.value) begin
				$error("read_value: expected %h, actual %h", exp_r.value, rv);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CAPREG_W-1:0] cfg_wdata;

	lfu_req_if req_ch ();
	lfu_rsp_if rsp_ch ();

	lfu_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int n_cap_writes;

	logic [KEY_W-1:0] key_pool [32];
	logic [KEY_W-1:0] corner_keys [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

	lfu_cache #(
		.CAPACITY   (N_ENTRIES),
		.COUNT_BITS (CNT_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard stop in case the block hangs; far above the slowest legal run.
	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Response side: check every transaction, then pick ready for the next edge.
	// A hold request from the main flow drops ready until the hold_left counter,
	// loaded from HOLD_CYCLES, runs out, so the block fills up and back-pressures its input.
	initial begin : rsp_side
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_response(rsp_ch.found, rsp_ch.read_value);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one transaction, idling first at the current sender rate.
	// Called at a rising edge; returns at the edge that accepted it, with
	// valid still high so back-to-back items need no extra edge.
	task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
	                         input logic [VAL_W-1:0] v);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.key    <= k;
		req_ch.value  <= v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(act, k, v);
	endtask

	// Drop valid and hold until every expected response has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write capacity_in_use only with the block idle.
	task automatic set_capacity(input logic [CAPREG_W-1:0] c);
		drain();
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_capacity(c);
		n_cap_writes++;
	endtask

	// Mostly keys from a pool sized a little above capacity so hits,
	// updates and evictions all happen; some fully random keys and corners.
	function automatic logic [KEY_W-1:0] pick_key(input int span);
		int sel;
		sel = $urandom_range(99);
		if (sel < 80) return key_pool[$urandom_range(span - 1)];
		if (sel < 95) return $urandom;
		return corner_keys[$urandom_range(3)];
	endfunction

	// Valid drops in the drain of the next phase or the final drain.
	task automatic run_phase(input logic [CAPREG_W-1:0] c, input int s_idle,
	                         input int r_stall, input int n, input bit with_hold);
		int span;
		logic [VAL_W-1:0] v;
		set_capacity(c);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		span = ((c > N_ENTRIES) ? N_ENTRIES : int'(c)) + 4;
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 5) hold_req = 1'b1;
			// pause the sender once per phase until the pipe is empty
			if (i == n / 2) drain();
			v = ($urandom_range(9) == 0) ? corner_keys[$urandom_range(3)] : $urandom;
			send_item(1'($urandom_range(1)), pick_key(span), v);
		end
	endtask

	initial begin : main_flow
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.action  <= ACT_GET;
		req_ch.key     <= '0;
		req_ch.value   <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		n_cap_writes   = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty miss, corner keys and values, hits and an update
		send_item(ACT_GET, 32'h0000_0000, 32'h0);
		send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ACT_GET, 32'h8000_0000, 32'h0);
		send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
		send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		send_item(ACT_GET, 32'h0000_0000, 32'h0);
		send_item(ACT_GET, 32'h0000_0000, 32'hDEAD_BEEF);
		// Shrink below occupancy: first insert evicts on the recency tie,
		// the next one evicts the fresh low-count entry
		set_capacity(5'd2);
		send_item(ACT_PUT, 32'h0000_0005, 32'h0000_0055);
		send_item(ACT_PUT, 32'h0000_0006, 32'h0000_0066);
		send_item(ACT_GET, 32'h0000_0005, 32'h0);
		// Capacity zero: puts are dropped, gets still hit stored entries
		set_capacity(5'd0);
		send_item(ACT_PUT, 32'h0000_0009, 32'h0000_0009);
		send_item(ACT_PUT, 32'h0000_0006, 32'h0000_0001);
		send_item(ACT_GET, 32'h0000_0006, 32'h0);
		// Register maximum acts as the full table
		set_capacity(5'd31);
		send_item(ACT_PUT, 32'h8000_0000, 32'hAAAA_5555);
		send_item(ACT_GET, 32'h8000_0000, 32'h0);
		send_item(ACT_GET, 32'h0000_0009, 32'h0);

		// Random phases: capacity, sender idle %, receiver stall %, items, hold flag
		run_phase(5'd16, 0, 0, 140, 1'b1);
		run_phase(5'd3, 54, 0, 110, 1'b0);
		run_phase(5'd1, 0, 54, 90, 1'b0);
		run_phase(5'd8, 37, 37, 120, 1'b0);
		run_phase(5'd17, 0, 0, 90, 1'b0);
		run_phase(5'd31, 54, 54, 100, 1'b0);
		run_phase(5'd0, 0, 54, 40, 1'b0);
		run_phase(5'd5, 37, 37, 80, 1'b0);
		run_phase(5'd12, 0, 0, 80, 1'b0);

		drain();
		repeat (LATENCY + 10) @(posedge clk);

		$display("Checked %0d transactions: %0d found, %0d evictions predicted,",
		         sb.n_checked, sb.n_hits, sb.n_evictions);
		$display("across %0d capacity writes with mixed sender idle and receiver stall.",
		         n_cap_writes);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
